// File: rtl/csi_pkg.sv
package csi_pkg;

  // Fixed field widths of the block.
  localparam int unsigned POS_BITS      = 32;
  localparam int unsigned ALPHA_IN_BITS = 16;
  localparam int unsigned AXES          = 3;

  // Angles live on a circle of 2048 * 256 units.
  localparam int unsigned ANGLE_FULL = 2048 * 256;
  localparam int unsigned ANGLE_HALF = ANGLE_FULL / 2;
  localparam int unsigned ANGLE_BITS = $clog2(ANGLE_FULL);

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [ANGLE_BITS-1:0] ang_t;

  typedef enum logic [1:0] {
    FN_CAPTURE  = 2'd0,
    FN_TELEPORT = 2'd1,
    FN_RENDER   = 2'd2,
    FN_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_NORM,
    ST_MUL,
    ST_DONE
  } state_e;

  // Slot store update requests, at most one of them high in a cycle.
  typedef struct packed {
    logic capture;
    logic teleport;
    logic clear_all;
  } store_cmd_t;

  // Sequencing shared by all interpolation lanes.
  typedef struct packed {
    logic diff_en;
    logic norm_en;
    logic step_en;
    logic alpha_bit;
  } lane_ctrl_t;

endpackage

// File: rtl/csi_slot_store.sv
module csi_slot_store #(
  parameter int unsigned CAMERAS = 2,
  parameter int unsigned SW      = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  csi_pkg::store_cmd_t     cmd_i,
  input  logic [SW-1:0]           wr_slot_i,
  input  csi_pkg::pos_t           wr_pos_i      [csi_pkg::AXES],
  input  csi_pkg::ang_t           wr_ang_i      [csi_pkg::AXES],
  input  logic [SW-1:0]           rd_slot_i,
  output logic                    rd_valid_o,
  output csi_pkg::pos_t           rd_pos_old_o  [csi_pkg::AXES],
  output csi_pkg::pos_t           rd_pos_now_o  [csi_pkg::AXES],
  output csi_pkg::ang_t           rd_ang_prev_o [csi_pkg::AXES],
  output csi_pkg::ang_t           rd_ang_curr_o [csi_pkg::AXES]
);

  logic [CAMERAS-1:0] valid_q;
  logic [CAMERAS-1:0] skip_q;

  csi_pkg::pos_t pos_old_q  [CAMERAS][csi_pkg::AXES];
  csi_pkg::pos_t pos_now_q  [CAMERAS][csi_pkg::AXES];
  csi_pkg::ang_t ang_prev_q [CAMERAS][csi_pkg::AXES];
  csi_pkg::ang_t ang_curr_q [CAMERAS][csi_pkg::AXES];

  // The old current snapshot only becomes previous on an ordinary capture;
  // a first capture or one after a teleport mark starts with no motion.
  logic keep_old;
  assign keep_old = valid_q[wr_slot_i] && !skip_q[wr_slot_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      skip_q  <= '0;
    end else begin
      priority if (cmd_i.clear_all) begin
        valid_q <= '0;
        skip_q  <= '0;
      end else if (cmd_i.capture) begin
        valid_q[wr_slot_i] <= 1'b1;
        skip_q[wr_slot_i]  <= 1'b0;
      end else if (cmd_i.teleport) begin
        skip_q[wr_slot_i] <= 1'b1;
      end
    end
  end

  // Snapshot data needs no reset: it is only used once the slot is valid.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int k = 0; k < csi_pkg::AXES; k++) begin
        pos_now_q[wr_slot_i][k]  <= wr_pos_i[k];
        ang_curr_q[wr_slot_i][k] <= wr_ang_i[k];
        pos_old_q[wr_slot_i][k]  <= keep_old ? pos_now_q[wr_slot_i][k] : wr_pos_i[k];
        ang_prev_q[wr_slot_i][k] <= keep_old ? ang_curr_q[wr_slot_i][k] : wr_ang_i[k];
      end
    end
  end

  assign rd_valid_o = valid_q[rd_slot_i];

  always_comb begin
    for (int k = 0; k < csi_pkg::AXES; k++) begin
      rd_pos_old_o[k]  = pos_old_q[rd_slot_i][k];
      rd_pos_now_o[k]  = pos_now_q[rd_slot_i][k];
      rd_ang_prev_o[k] = ang_prev_q[rd_slot_i][k];
      rd_ang_curr_o[k] = ang_curr_q[rd_slot_i][k];
    end
  end

endmodule

// File: rtl/csi_lerp_lane.sv
module csi_lerp_lane #(
  parameter int unsigned W    = 32,
  parameter bit          WRAP = 1'b0
) (
  input  logic                clk_i,
  input  csi_pkg::lane_ctrl_t ctrl_i,
  input  logic [W-1:0]        prev_i,
  input  logic [W-1:0]        curr_i,
  output logic [W-1:0]        result_o
);

  localparam int unsigned DW = W + 1;

  logic [W-1:0]         prev_q;
  logic signed [DW-1:0] diff_q;
  logic signed [DW-1:0] wrapped;
  logic                 neg_q;
  logic [DW-1:0]        mag_q;
  logic [DW-1:0]        acc_q;
  logic [DW:0]          sum;
  logic                 ext_p;
  logic                 ext_c;

  // Positions are signed, angles are plain residues on the circle.
  assign ext_p = WRAP ? 1'b0 : prev_i[W-1];
  assign ext_c = WRAP ? 1'b0 : curr_i[W-1];

  // Take the shorter way round the circle.
  always_comb begin
    wrapped = diff_q;
    if (WRAP) begin
      if (diff_q > $signed(DW'(csi_pkg::ANGLE_HALF))) begin
        wrapped = diff_q - $signed(DW'(csi_pkg::ANGLE_FULL));
      end else if (diff_q < -$signed(DW'(csi_pkg::ANGLE_HALF))) begin
        wrapped = diff_q + $signed(DW'(csi_pkg::ANGLE_FULL));
      end
    end
  end

  // Shift-and-add over the fraction, least significant bit first. Each step
  // drops one low product bit, so the final value is the truncated product.
  assign sum = {1'b0, acc_q} + (ctrl_i.alpha_bit ? {1'b0, mag_q} : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      prev_q <= prev_i;
      diff_q <= $signed({ext_c, curr_i}) - $signed({ext_p, prev_i});
    end
    if (ctrl_i.norm_en) begin
      neg_q <= wrapped[DW-1];
      mag_q <= wrapped[DW-1] ? DW'(-wrapped) : DW'(wrapped);
      acc_q <= '0;
    end else if (ctrl_i.step_en) begin
      acc_q <= sum[DW:1];
    end
  end

  // Truncation toward zero: scale the magnitude, then apply the sign.
  assign result_o = neg_q ? (prev_q - acc_q[W-1:0]) : (prev_q + acc_q[W-1:0]);

endmodule

// File: rtl/camera_snapshot_interpolator.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   func, cam_slot, pos_x/y/z, yaw/pitch/roll, alpha
// out       output     out_valid_o / out_stall_i valid_res, out_x/y/z, out_yaw/pitch/roll
// cfg       input      cfg_we_i                  cfg_wdata_i (interp_enable)
//
// Capture, teleport mark and clear all complete in the cycle of their transfer. A render
// holds the input stalled while it forms the differences, wraps and takes magnitudes, runs
// the bit-serial multiplier, which consumes one fraction bit per cycle, and loads the
// output register. Reset is asynchronous and active low; it clears all slots and sets
// interp_enable. A stalled result waits in the output register while the next item is
// taken; a following render waits in ST_DONE until that result is taken.
module camera_snapshot_interpolator #(
  parameter int unsigned CAMERAS    = 2,
  parameter int unsigned ALPHA_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            func_i,
  input  logic                                  cam_slot_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   pos_x_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   pos_y_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   pos_z_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   yaw_in_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   pitch_in_i,
  input  logic signed [csi_pkg::POS_BITS-1:0]   roll_in_i,
  input  logic [csi_pkg::ALPHA_IN_BITS-1:0]     alpha_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  valid_res_o,
  output logic signed [csi_pkg::POS_BITS-1:0]   out_x_o,
  output logic signed [csi_pkg::POS_BITS-1:0]   out_y_o,
  output logic signed [csi_pkg::POS_BITS-1:0]   out_z_o,
  output logic [csi_pkg::ANGLE_BITS-1:0]        out_yaw_o,
  output logic [csi_pkg::ANGLE_BITS-1:0]        out_pitch_o,
  output logic [csi_pkg::ANGLE_BITS-1:0]        out_roll_o
);

  localparam int unsigned SW    = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int unsigned CNT_W = $clog2(ALPHA_BITS);
  localparam int unsigned AW    = (ALPHA_BITS > csi_pkg::ALPHA_IN_BITS) ?
                                  ALPHA_BITS : csi_pkg::ALPHA_IN_BITS;
  localparam logic [AW-1:0] AMAX = AW'((1 << ALPHA_BITS) - 1);

  csi_pkg::state_e     state_q, state_d;
  logic [SW-1:0]       slot_q;
  logic                ok_q;
  logic [ALPHA_BITS-1:0] alpha_sr_q, alpha_sr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                interp_enable_q;
  logic                out_valid_q;
  logic                load_out;

  logic                valid_res_q;
  csi_pkg::pos_t       out_pos_q [csi_pkg::AXES];
  csi_pkg::ang_t       out_ang_q [csi_pkg::AXES];

  csi_pkg::func_e      func;
  logic                in_accept;
  logic                in_range;
  logic                render_go;
  logic [SW-1:0]       slot_idx;
  logic [SW-1:0]       rd_slot;
  logic [AW-1:0]       alpha_ext;
  logic [ALPHA_BITS-1:0] alpha_sat;

  csi_pkg::store_cmd_t store_cmd;
  csi_pkg::lane_ctrl_t lane_ctrl;

  csi_pkg::pos_t       wr_pos    [csi_pkg::AXES];
  csi_pkg::ang_t       wr_ang    [csi_pkg::AXES];
  logic                rd_valid;
  csi_pkg::pos_t       pos_old   [csi_pkg::AXES];
  csi_pkg::pos_t       pos_now   [csi_pkg::AXES];
  csi_pkg::ang_t       ang_prev  [csi_pkg::AXES];
  csi_pkg::ang_t       ang_curr  [csi_pkg::AXES];
  csi_pkg::pos_t       pos_res   [csi_pkg::AXES];
  csi_pkg::ang_t       ang_res   [csi_pkg::AXES];

  // ------------------------------------------------------------------
  // Input decoding. Only the idle state takes a transfer.
  // ------------------------------------------------------------------
  assign in_stall_o = (state_q != csi_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign func       = csi_pkg::func_e'(func_i);
  assign in_range   = (32'(cam_slot_i) < CAMERAS);
  assign slot_idx   = in_range ? SW'(cam_slot_i) : '0;
  assign render_go  = in_accept && (func == csi_pkg::FN_RENDER);

  // During a render the slot is held; otherwise the read follows the input.
  assign rd_slot = (state_q == csi_pkg::ST_IDLE) ? slot_idx : slot_q;

  assign store_cmd.capture   = in_accept && (func == csi_pkg::FN_CAPTURE) && in_range;
  assign store_cmd.teleport  = in_accept && (func == csi_pkg::FN_TELEPORT) && in_range;
  assign store_cmd.clear_all = in_accept && (func == csi_pkg::FN_CLEAR);

  // Angles are stored reduced to the circle, that is their low bits.
  assign wr_pos[0] = pos_x_i;
  assign wr_pos[1] = pos_y_i;
  assign wr_pos[2] = pos_z_i;
  assign wr_ang[0] = yaw_in_i[csi_pkg::ANGLE_BITS-1:0];
  assign wr_ang[1] = pitch_in_i[csi_pkg::ANGLE_BITS-1:0];
  assign wr_ang[2] = roll_in_i[csi_pkg::ANGLE_BITS-1:0];

  // The fraction saturates just below one.
  assign alpha_ext = AW'(alpha_i);
  assign alpha_sat = (alpha_ext > AMAX) ? AMAX[ALPHA_BITS-1:0] : alpha_ext[ALPHA_BITS-1:0];

  // ------------------------------------------------------------------
  // Configuration register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      interp_enable_q <= cfg_wdata_i;
    end
  end

  // ------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_sr_q <= alpha_sr_d;
    cnt_q      <= cnt_d;
    if (render_go) begin
      slot_q <= slot_idx;
      // A render of an empty, out-of-range or disabled slot still goes
      // through the lanes; its result is simply forced to zero.
      ok_q   <= in_range && interp_enable_q && rd_valid;
    end
  end

  always_comb begin
    state_d    = state_q;
    alpha_sr_d = alpha_sr_q;
    cnt_d      = cnt_q;
    lane_ctrl  = '0;
    load_out   = 1'b0;
    unique case (state_q)
      csi_pkg::ST_IDLE: begin
        if (render_go) begin
          state_d    = csi_pkg::ST_DIFF;
          alpha_sr_d = alpha_sat;
          cnt_d      = CNT_W'(ALPHA_BITS - 1);
        end
      end
      csi_pkg::ST_DIFF: begin
        lane_ctrl.diff_en = 1'b1;
        state_d           = csi_pkg::ST_NORM;
      end
      csi_pkg::ST_NORM: begin
        lane_ctrl.norm_en = 1'b1;
        state_d           = csi_pkg::ST_MUL;
      end
      csi_pkg::ST_MUL: begin
        lane_ctrl.step_en   = 1'b1;
        lane_ctrl.alpha_bit = alpha_sr_q[0];
        alpha_sr_d          = alpha_sr_q >> 1;
        if (cnt_q == '0) begin
          state_d = csi_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      csi_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = csi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csi_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Snapshot store and interpolation lanes.
  // ------------------------------------------------------------------
  csi_slot_store #(
    .CAMERAS (CAMERAS),
    .SW      (SW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (store_cmd),
    .wr_slot_i     (slot_idx),
    .wr_pos_i      (wr_pos),
    .wr_ang_i      (wr_ang),
    .rd_slot_i     (rd_slot),
    .rd_valid_o    (rd_valid),
    .rd_pos_old_o  (pos_old),
    .rd_pos_now_o  (pos_now),
    .rd_ang_prev_o (ang_prev),
    .rd_ang_curr_o (ang_curr)
  );

  for (genvar g = 0; g < csi_pkg::AXES; g++) begin : g_axis
    csi_lerp_lane #(
      .W    (csi_pkg::POS_BITS),
      .WRAP (1'b0)
    ) u_pos_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .prev_i   (pos_old[g]),
      .curr_i   (pos_now[g]),
      .result_o (pos_res[g])
    );

    csi_lerp_lane #(
      .W    (csi_pkg::ANGLE_BITS),
      .WRAP (1'b1)
    ) u_ang_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .prev_i   (ang_prev[g]),
      .curr_i   (ang_curr[g]),
      .result_o (ang_res[g])
    );
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      valid_res_q <= ok_q;
      for (int k = 0; k < csi_pkg::AXES; k++) begin
        out_pos_q[k] <= ok_q ? pos_res[k] : '0;
        out_ang_q[k] <= ok_q ? ang_res[k] : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign out_x_o     = out_pos_q[0];
  assign out_y_o     = out_pos_q[1];
  assign out_z_o     = out_pos_q[2];
  assign out_yaw_o   = out_ang_q[0];
  assign out_pitch_o = out_ang_q[1];
  assign out_roll_o  = out_ang_q[2];

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  a_render_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_go |=> (state_q == csi_pkg::ST_DIFF))
    else $error("render transfer did not start the lanes");

  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csi_pkg::ST_MUL) && (cnt_q == '0) |=> (state_q == csi_pkg::ST_DONE))
    else $error("multiplier ran past its last fraction bit");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == csi_pkg::ST_DONE))
    else $error("result appeared without a finished render");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && (state_q != csi_pkg::ST_DONE) |=> !out_valid_q)
    else $error("taken result was not removed");

  a_idle_no_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csi_pkg::ST_IDLE) |-> !(lane_ctrl.diff_en || lane_ctrl.norm_en ||
                                        lane_ctrl.step_en))
    else $error("lanes active while idle");

endmodule
